/* rtl/tmrb_pkg.sv */
// Package for the timer bank: command codes, FSM state type, fixed widths.
// No dependencies.
package tmrb_pkg;
	localparam int KIND_W = 2;
	localparam int IDX_W = 4;
	localparam int DLY_W = 32;
	localparam int MASK_W = 16;
	localparam int PORT_TIME_W = 48;

	typedef enum logic [KIND_W-1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2,
		KIND_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WALK,
		ST_DIV,
		ST_OUT
	} state_t;
endpackage

/* rtl/one_shot_periodic_timer_bank.sv */
// Timer bank: NUM_TIMERS slots in a ring of cells rotated past one check unit.
// Start/stop: accepted while idle, no result. Tick: a walk over all NUM_TIMERS slots,
// with the serial divider run for each firing periodic slot, then the result is loaded
// into the output register.
// Input stalled from tick accept until the result is loaded.
// arst_n clears every slot and the output register asynchronously.
// Depends on tmrb_pkg, tmrb_cell, tmrb_div.
module one_shot_periodic_timer_bank
	import tmrb_pkg::*;
#(
	parameter int NUM_TIMERS = 16,
	parameter int TIME_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [KIND_W-1:0]      kind,
	input  logic [IDX_W-1:0]       timer_index,
	input  logic [DLY_W-1:0]       first_delay,
	input  logic [DLY_W-1:0]       period_ms,
	input  logic [PORT_TIME_W-1:0] now_ms,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [MASK_W-1:0]      fired_mask,
	output logic                   deadline_valid,
	output logic [PORT_TIME_W-1:0] next_deadline_ms,
	output logic [PORT_TIME_W-1:0] wait_ms
);
	localparam int TW = TIME_BITS;
	localparam int N = NUM_TIMERS;
	localparam int PW = (N > 1) ? $clog2(N) : 1;
	localparam int MPW = $clog2(MASK_W);
	localparam logic [TW-1:0] TMAX = '1;

	logic             run[N];
	logic [DLY_W-1:0] dly[N], per[N];
	logic [TW-1:0]    st[N], lst[N];
	logic             nrun[N];
	logic [DLY_W-1:0] ndly[N], nper[N];
	logic [TW-1:0]    nst[N], nlst[N];
	logic             shift;
	logic [N-1:0]     clr;
	logic [N-1:0]     arm_sel;
	logic [N-1:0]     cell_en;

	state_t state_q, state_d;
	logic [PW-1:0]  pos_q;     // slot index currently at cell 0
	logic [PW-1:0]  cnt_q;
	logic [TW-1:0]  now_q;
	logic [MASK_W-1:0] mask_q;
	logic           any_q;
	logic [TW-1:0]  best_q;
	logic [TW-1:0]  due_q;

	// Head cell evaluation
	logic [TW-1:0] base, addend, due_c, dlp, dl_c, new_last;
	logic [TW:0]   sum1, sum2;
	logic          periodic, fire, div_done, div_go;
	logic [TW-1:0] div_prod;
	logic          has_dl;

	logic          acc_in;
	kind_t         k;
	logic [TW-1:0] now_in;
	logic [PW-1:0] idx_sel;
	logic          idx_ok;
	logic          arm, stop_hit;
	logic          out_load;

	assign k = kind_t'(kind);
	assign now_in = TW'(now_ms);
	assign acc_in = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign idx_sel = PW'(timer_index);
	assign idx_ok = int'(timer_index) < N;
	// result register frees up in the same cycle it is taken
	assign out_load = (state_q == ST_OUT) && (!out_valid || !out_stall);

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			tmrb_cell #(.TW(TW)) u_cell (
				.clk, .arst_n, .shift(cell_en[g]), .clr(clr[g]),
				.in_run(nrun[g]), .in_dly(ndly[g]), .in_per(nper[g]),
				.in_start(nst[g]), .in_last(nlst[g]),
				.run(run[g]), .dly(dly[g]), .per(per[g]), .start(st[g]), .last(lst[g])
			);
		end
	endgenerate

	assign periodic = per[0] != '0;
	assign base = (periodic && lst[0] != '0) ? lst[0] : st[0];
	assign addend = (periodic && lst[0] != '0) ? TW'(per[0]) : TW'(dly[0]);
	assign sum1 = {1'b0, base} + {1'b0, addend};
	assign due_c = sum1[TW] ? TMAX : sum1[TW-1:0];
	assign fire = run[0] && (periodic ? (now_q > due_c) : (now_q >= due_c));
	assign new_last = due_q + div_prod;
	assign dlp = (state_q == ST_DIV) ? new_last : due_c;
	assign sum2 = {1'b0, dlp} + {1'b0, TW'(per[0])};
	assign dl_c = !periodic ? due_c : (sum2[TW] ? TMAX : sum2[TW-1:0]);
	assign has_dl = run[0] && (periodic || !fire);
	assign div_go = (state_q == ST_WALK) && fire && periodic;

	// ring is at home whenever the FSM is idle
	assign arm = (state_q == ST_IDLE) && acc_in && (k == KIND_START) && idx_ok
		&& !run[idx_sel];
	assign stop_hit = (state_q == ST_IDLE) && acc_in && (k == KIND_STOP) && idx_ok;

	tmrb_div #(.TW(TW)) u_div (
		.clk, .arst_n, .go(div_go), .num(now_q - due_c), .den(per[0]),
		.done(div_done), .prod(div_prod)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (acc_in && k == KIND_TICK) state_d = ST_WALK;
			ST_WALK: begin
				if (div_go) state_d = ST_DIV;
				else if (cnt_q == PW'(N - 1)) state_d = ST_OUT;
			end
			ST_DIV: if (div_done) state_d = (cnt_q == PW'(N - 1)) ? ST_OUT : ST_WALK;
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// ring rotation; the head cell's record may be rewritten on its way round
	always_comb begin
		shift = ((state_q == ST_WALK) && !div_go) || ((state_q == ST_DIV) && div_done);
		clr = '0;
		arm_sel = '0;
		for (int i = 0; i < N; i++) begin
			nrun[i] = run[(i + 1) % N];
			ndly[i] = dly[(i + 1) % N];
			nper[i] = per[(i + 1) % N];
			nst[i] = st[(i + 1) % N];
			nlst[i] = lst[(i + 1) % N];
		end
		// head moves to the tail
		nrun[N-1] = run[0] && !(fire && !periodic);
		ndly[N-1] = (fire && !periodic) ? '0 : dly[0];
		nper[N-1] = per[0];
		nst[N-1] = (fire && !periodic) ? '0 : st[0];
		nlst[N-1] = (state_q == ST_DIV) ? new_last : ((fire && !periodic) ? '0 : lst[0]);
		if (arm) arm_sel[idx_sel] = 1'b1;
		if (stop_hit) clr[idx_sel] = 1'b1;
		// start loads the addressed cell in place
		for (int i = 0; i < N; i++) begin
			cell_en[i] = shift || arm_sel[i];
			if (arm_sel[i]) begin
				nrun[i] = 1'b1;
				ndly[i] = first_delay;
				nper[i] = period_ms;
				nst[i] = now_in;
				nlst[i] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pos_q <= '0;
			cnt_q <= '0;
			out_valid <= 1'b0;
			mask_q <= '0;
			any_q <= 1'b0;
			fired_mask <= '0;
			deadline_valid <= 1'b0;
			next_deadline_ms <= '0;
			wait_ms <= '0;
		end else begin
			state_q <= state_d;
			out_valid <= out_load || (out_valid && out_stall);
			if (state_q == ST_IDLE && acc_in && k == KIND_TICK) begin
				cnt_q <= '0;
				mask_q <= '0;
				any_q <= 1'b0;
			end
			if (shift) begin
				cnt_q <= cnt_q + PW'(1);
				pos_q <= (pos_q == PW'(N - 1)) ? '0 : pos_q + PW'(1);
				if (fire && int'(pos_q) < MASK_W) mask_q[MPW'(pos_q)] <= 1'b1;
				if (has_dl && (!any_q || dl_c < best_q)) any_q <= 1'b1;
			end
			if (out_load) begin
				fired_mask <= mask_q;
				deadline_valid <= any_q;
				next_deadline_ms <= any_q ? PORT_TIME_W'(best_q) : '0;
				wait_ms <= (any_q && best_q > now_q) ? PORT_TIME_W'(best_q - now_q) : '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && acc_in) now_q <= now_in;
		if (div_go) due_q <= due_c;
		if (shift && has_dl && (!any_q || dl_c < best_q)) best_q <= dl_c;
	end
endmodule

/* rtl/tmrb_cell.sv */
// One timer slot: holds its state and passes its record to the next cell on shift.
// Depends on tmrb_pkg.
module tmrb_cell
	import tmrb_pkg::*;
#(
	parameter int TW = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             shift,
	input  logic             clr,
	input  logic             in_run,
	input  logic [DLY_W-1:0] in_dly,
	input  logic [DLY_W-1:0] in_per,
	input  logic [TW-1:0]    in_start,
	input  logic [TW-1:0]    in_last,
	output logic             run,
	output logic [DLY_W-1:0] dly,
	output logic [DLY_W-1:0] per,
	output logic [TW-1:0]    start,
	output logic [TW-1:0]    last
);
	logic             run_q;
	logic [DLY_W-1:0] dly_q, per_q;
	logic [TW-1:0]    start_q, last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			dly_q <= '0;
			per_q <= '0;
			start_q <= '0;
			last_q <= '0;
		end else if (clr) begin
			run_q <= 1'b0;
			dly_q <= '0;
			per_q <= '0;
			start_q <= '0;
			last_q <= '0;
		end else if (shift) begin
			run_q <= in_run;
			dly_q <= in_dly;
			per_q <= in_per;
			start_q <= in_start;
			last_q <= in_last;
		end
	end

	assign run = run_q;
	assign dly = dly_q;
	assign per = per_q;
	assign start = start_q;
	assign last = last_q;
endmodule

/* rtl/tmrb_div.sv */
// Restoring divider, one quotient bit per cycle; returns q*d for the catch-up.
// Depends on tmrb_pkg.
module tmrb_div
	import tmrb_pkg::*;
#(
	parameter int TW = 48
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [TW-1:0]    num,
	input  logic [DLY_W-1:0] den,
	output logic             done,
	output logic [TW-1:0]    prod
);
	localparam int CW = $clog2(TW + 1);
	logic [DLY_W-1:0] rem_q, den_q;
	logic [TW-1:0]    num_q, prod_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [DLY_W+1:0] trial;
	logic [DLY_W:0]   shifted;

	// prod accumulates floor(num/den)*den directly: each quotient bit adds den<<k,
	// done MSB first as prod = 2*prod + den. The remainder stays below den.
	assign shifted = {rem_q, num_q[TW-1]};
	assign trial = {1'b0, shifted} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(TW);
			end else if (busy_q) begin
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
			prod_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[TW-2:0], 1'b0};
			if (!trial[DLY_W+1]) begin
				rem_q <= trial[DLY_W-1:0];
				prod_q <= {prod_q[TW-2:0], 1'b0} + TW'(den_q);
			end else begin
				rem_q <= shifted[DLY_W-1:0];
				prod_q <= {prod_q[TW-2:0], 1'b0};
			end
		end
	end

	assign prod = prod_q;
endmodule

/* tb/tb_one_shot_periodic_timer_bank.sv */
`timescale 1ns / 100ps
// Self-checking bench for one_shot_periodic_timer_bank: directed table, then random bursts.
// A behavioral model of the slot bank predicts each tick result. Depends on tmrb_pkg.
module tb_one_shot_periodic_timer_bank;
	import tmrb_pkg::*;

	localparam int NSLOT = 16;
	localparam logic [47:0] TMAX = 48'hFFFF_FFFF_FFFF;
	localparam int LIMIT = 4_000_000;

	typedef struct packed {
		logic [15:0] mask;
		logic        dvalid;
		logic [47:0] deadline;
		logic [47:0] wait_t;
	} tick_res_t;

	typedef struct {
		kind_t       k;
		logic [3:0]  idx;
		logic [31:0] dly;
		logic [31:0] per;
		logic [47:0] now;
		bit          has_exp;
		tick_res_t   exp;
	} row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic [1:0] kind = '0;
	logic [3:0] timer_index = '0;
	logic [31:0] first_delay = '0;
	logic [31:0] period_ms = '0;
	logic [47:0] now_ms = '0;
	logic out_valid;
	logic out_stall = 0;
	logic [15:0] fired_mask;
	logic deadline_valid;
	logic [47:0] next_deadline_ms;
	logic [47:0] wait_ms;

	bit          run_on [NSLOT];
	logic [31:0] s_dly [NSLOT];
	logic [31:0] s_per [NSLOT];
	logic [47:0] s_start [NSLOT];
	logic [47:0] s_last [NSLOT];

	tick_res_t pending_ticks[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;

	one_shot_periodic_timer_bank u_top (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	function automatic logic [47:0] add_sat(logic [47:0] a, logic [47:0] b);
		logic [48:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[48] ? TMAX : s[47:0];
	endfunction

	function automatic void clear_slot(int i);
		run_on[i] = 0;
		s_dly[i] = '0;
		s_per[i] = '0;
		s_start[i] = '0;
		s_last[i] = '0;
	endfunction

	// Applies one item to the slot model; returns 1 and the result for a tick.
	function automatic bit bank_step(kind_t k, logic [3:0] idx, logic [31:0] dly,
			logic [31:0] per, logic [47:0] now, output tick_res_t r);
		logic [47:0] due, dl, p, best;
		bit has, any;
		r = '0;
		any = 0;
		best = '0;
		case (k)
			KIND_START: begin
				if (!run_on[idx]) begin
					run_on[idx] = 1;
					s_dly[idx] = dly;
					s_per[idx] = per;
					s_start[idx] = now;
					s_last[idx] = '0;
				end
				return 0;
			end
			KIND_STOP: begin
				clear_slot(idx);
				return 0;
			end
			KIND_TICK: begin
				for (int i = 0; i < NSLOT; i++) begin
					has = 0;
					dl = '0;
					if (run_on[i]) begin
						p = {16'd0, s_per[i]};
						if (p == 0) begin
							due = add_sat(s_start[i], {16'd0, s_dly[i]});
							if (now >= due) begin
								clear_slot(i);
								r.mask[i] = 1;
							end else begin
								has = 1;
								dl = due;
							end
						end else begin
							due = (s_last[i] == 0) ? add_sat(s_start[i], {16'd0, s_dly[i]})
								: add_sat(s_last[i], p);
							has = 1;
							if (now > due) begin
								s_last[i] = due + p * ((now - due) / p);
								dl = add_sat(s_last[i], p);
								r.mask[i] = 1;
							end else begin
								dl = add_sat(due, p);
							end
						end
					end
					if (has && (!any || dl < best)) begin
						best = dl;
						any = 1;
					end
				end
				r.dvalid = any;
				r.deadline = any ? best : '0;
				r.wait_t = (any && best > now) ? best - now : '0;
				return 1;
			end
			default: return 0;
		endcase
	endfunction

	// Offers one item and waits until it is accepted.
	task automatic send_item(kind_t k, logic [3:0] idx, logic [31:0] dly,
			logic [31:0] per, logic [47:0] now, bit has_exp, tick_res_t exp);
		tick_res_t r;
		in_valid <= 1;
		kind <= k;
		timer_index <= idx;
		first_delay <= dly;
		period_ms <= per;
		now_ms <= now;
		do @(posedge clk); while (in_stall);
		if (bank_step(k, idx, dly, per, now, r)) begin
			if (has_exp && r !== exp) begin
				$error("tick result exp %h got %h", exp, r);
				errors++;
			end
			if (has_exp)
				pending_ticks = {pending_ticks, exp};
			else
				pending_ticks = {pending_ticks, r};
		end
	endtask

	task automatic idle_cycles(int n);
		in_valid <= 0;
		repeat (n) @(posedge clk);
	endtask

	always @(posedge clk) begin
		tick_res_t e;
		if (out_valid && !out_stall) begin
			if (pending_ticks.size() == 0) begin
				$error("unexpected result");
				errors++;
			end else begin
				e = pending_ticks.pop_front();
				if (fired_mask !== e.mask) begin
					$error("fired_mask exp %h got %h", e.mask, fired_mask);
					errors++;
				end
				if (deadline_valid !== e.dvalid) begin
					$error("deadline_valid exp %b got %b", e.dvalid, deadline_valid);
					errors++;
				end
				if (next_deadline_ms !== e.deadline) begin
					$error("next_deadline_ms exp %h got %h", e.deadline, next_deadline_ms);
					errors++;
				end
				if (wait_ms !== e.wait_t) begin
					$error("wait_ms exp %h got %h", e.wait_t, wait_ms);
					errors++;
				end
			end
		end
	end

	// Receiver stall pattern; one long hold-off that backs up into the sender.
	initial begin
		int n;
		@(posedge arst_n);
		repeat (300) @(posedge clk);
		out_stall <= 1;
		repeat (3000) @(posedge clk);
		while (!stim_done) begin
			n = $urandom_range(0, 3);
			if ($urandom_range(0, 9) == 0) begin
				out_stall <= 0;
				repeat ($urandom_range(20, 80)) @(posedge clk);
			end else begin
				out_stall <= (n == 0) ? 1'b0 : ($urandom_range(0, 2) == 0);
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
		out_stall <= 0;
	end

	row_t dir [$];

	function automatic row_t mk(kind_t k, int idx, logic [31:0] d, logic [31:0] p,
			logic [47:0] n);
		row_t r;
		r.k = k;
		r.idx = 4'(idx);
		r.dly = d;
		r.per = p;
		r.now = n;
		r.has_exp = 0;
		r.exp = '0;
		return r;
	endfunction

	initial begin
		row_t r;
		tick_res_t none;
		logic [47:0] t;
		kind_t k;
		int burst, idx;
		none = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// tick with nothing armed: all zero
		r = mk(KIND_TICK, 0, 0, 0, TMAX); r.has_exp = 1; r.exp = none; dir = {dir, r};
		dir = {dir, mk(KIND_START, 0, 10, 0, 100)};
		r = mk(KIND_TICK, 0, 0, 0, 105); r.has_exp = 1;
		r.exp = '{16'h0, 1'b1, 48'd110, 48'd5}; dir = {dir, r};
		// one-shot fires when time reaches its due time
		r = mk(KIND_TICK, 0, 0, 0, 110); r.has_exp = 1; r.exp = none; r.exp.mask = 16'h1;
		dir = {dir, r};
		dir = {dir, mk(KIND_START, 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, TMAX - 5)};
		dir = {dir, mk(KIND_START, 15, 1, 1, 0)};  // running slot ignores start
		dir = {dir, mk(KIND_START, 3, 0, 7, 1000)};
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 1000)}; // periodic: not strictly past
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 1050)}; // skips missed periods
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 1057)};
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 1058)};
		dir = {dir, mk(KIND_TICK, 0, 0, 0, TMAX)};
		dir = {dir, mk(KIND_STOP, 9, 0, 0, 0)};    // stop on idle slot
		dir = {dir, mk(KIND_STOP, 15, 0, 0, 0)};
		dir = {dir, mk(KIND_STOP, 3, 0, 0, 0)};
		dir = {dir, mk(KIND_NONE, 5, 1, 1, 1)};    // unused kind
		dir = {dir, mk(KIND_START, 7, 0, 0, 0)};
		dir = {dir, mk(KIND_START, 8, 5, 3, 0)};   // periodic, first due at 5, period 3
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 0)};
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 6)};
		dir = {dir, mk(KIND_TICK, 0, 0, 0, 200)};
		dir = {dir, mk(KIND_STOP, 8, 0, 0, 0)};
		r = mk(KIND_TICK, 0, 0, 0, 0); r.has_exp = 1; r.exp = none; dir = {dir, r};
		foreach (dir[i])
			send_item(dir[i].k, dir[i].idx, dir[i].dly, dir[i].per, dir[i].now,
				dir[i].has_exp, dir[i].exp);
		in_valid <= 0;

		t = 48'($urandom_range(0, 1000));
		for (int n = 0; n < 580; ) begin
			burst = $urandom_range(1, 12);
			for (int b = 0; b < burst && n < 580; b++, n++) begin
				idx = $urandom_range(0, 15);
				case ($urandom_range(0, 9))
					0, 1, 2, 3: k = KIND_TICK;
					4, 5, 6: k = KIND_START;
					7, 8: k = KIND_STOP;
					default: k = ($urandom_range(0, 3) == 0) ? KIND_NONE : KIND_TICK;
				endcase
				if ($urandom_range(0, 30) == 0)
					t = 48'({$urandom, $urandom});
				else
					t = add_sat(t, 48'($urandom_range(0, 40)));
				if ($urandom_range(0, 15) == 0)
					send_item(k, 4'(idx), $urandom, $urandom, t, 0, none);
				else
					send_item(k, 4'(idx), $urandom_range(0, 60),
						($urandom_range(0, 2) == 0) ? 32'd0 : $urandom_range(1, 25),
						t, 0, none);
			end
			if ($urandom_range(0, 2) != 0)
				idle_cycles($urandom_range(1, 30));
		end
		in_valid <= 0;
		stim_done = 1;
		while (pending_ticks.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_ticks.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
